// ----- sv/rcsd_pkg.sv -----
// Shared types, widths and codes for the run-length raster span decoder.
`default_nettype none

package rcsd_pkg;

  // Default geometry of the packet format
  localparam int MAX_ROWS_DEF         = 512;
  localparam int MAX_COLUMNS_DEF      = 512;
  localparam int HEADER_WORDS_DEF     = 5;
  localparam int ROW_HEADER_WORDS_DEF = 1;
  localparam int COLS_FIELD_POS_DEF   = 3;
  localparam int ROWS_FIELD_POS_DEF   = 4;

  // Field widths
  localparam int WORD_W     = 16;
  localparam int ROW_NUM_W  = 9;
  localparam int COL_NUM_W  = 9;
  localparam int SPAN_LEN_W = 8;
  localparam int LEVEL_W    = 8;
  localparam int COLOR_W    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // Divider operand width and queue depth
  localparam int DIV_W       = 9;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_FLAGS     = 4'd0,
    CFG_TRAIL_FLAGS    = 4'd1,
    CFG_TOTAL_LEVELS   = 4'd2,
    CFG_PALETTE_COLORS = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ROWHDR,
    PH_DATA
  } parse_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_CLASS,
    BK_COLOR,
    BK_DONE
  } back_state_t;

  // Span command from the parser to the colour stage
  typedef struct packed {
    logic [ROW_NUM_W-1:0]  row;
    logic [COL_NUM_W-1:0]  col;
    logic [SPAN_LEN_W-1:0] len;
    logic [LEVEL_W-1:0]    level;
    logic                  clip;
    logic                  done;
  } span_cmd_t;

  // Result transaction
  typedef struct packed {
    logic [ROW_NUM_W-1:0]  row_number;
    logic [COL_NUM_W-1:0]  start_column;
    logic [SPAN_LEN_W-1:0] span_length;
    logic [LEVEL_W-1:0]    level_byte;
    logic [COLOR_W-1:0]    color_index;
    logic                  clipped;
    logic                  packet_done;
  } result_t;

  // Register write seen by the colour stage
  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- sv/rcsd_ifs.sv -----
// Channel interfaces: input halfwords, span results and register writes.
`default_nettype none

interface rcsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rcsd_pkg::WORD_W-1:0]   word;
  logic                          packet_start;
  modport source (output valid, word, packet_start, input ready);
  modport sink   (input valid, word, packet_start, output ready);
endinterface

interface rcsd_out_if;
  logic                             valid;
  logic                             ready;
  logic [rcsd_pkg::ROW_NUM_W-1:0]   row_number;
  logic [rcsd_pkg::COL_NUM_W-1:0]   start_column;
  logic [rcsd_pkg::SPAN_LEN_W-1:0]  span_length;
  logic [rcsd_pkg::LEVEL_W-1:0]     level_byte;
  logic [rcsd_pkg::COLOR_W-1:0]     color_index;
  logic                             clipped;
  logic                             packet_done;
  modport source (output valid, row_number, start_column, span_length, level_byte,
                  color_index, clipped, packet_done, input ready);
  modport sink   (input valid, row_number, start_column, span_length, level_byte,
                  color_index, clipped, packet_done, output ready);
endinterface

interface rcsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcsd_pkg::CFG_IDX_W-1:0]    index;
  logic [rcsd_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/rcsd_front.sv -----
// Packet parser: walks header, row headers and run/level halfwords into span commands.
`default_nettype none

module rcsd_front #(
  parameter int MAX_ROWS         = rcsd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS      = rcsd_pkg::MAX_COLUMNS_DEF,
  parameter int HEADER_WORDS     = rcsd_pkg::HEADER_WORDS_DEF,
  parameter int ROW_HEADER_WORDS = rcsd_pkg::ROW_HEADER_WORDS_DEF,
  parameter int COLS_FIELD_POS   = rcsd_pkg::COLS_FIELD_POS_DEF,
  parameter int ROWS_FIELD_POS   = rcsd_pkg::ROWS_FIELD_POS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rcsd_pkg::WORD_W-1:0] in_word,
  input  wire logic                        in_packet_start,
  output logic                             push,
  output rcsd_pkg::span_cmd_t              push_cmd,
  input  wire logic                        q_full
);

  localparam int HW_MAX = (HEADER_WORDS > ROW_HEADER_WORDS) ? HEADER_WORDS : ROW_HEADER_WORDS;
  localparam int HCW    = $clog2(HW_MAX + 1);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int SUM_W  = ((COL_W > 8) ? COL_W : 8) + 1;
  localparam int RWL_W  = rcsd_pkg::WORD_W - 1;

  rcsd_pkg::parse_phase_t phase_r, phase_nxt;
  logic [HCW-1:0]   hcnt_r, hcnt_nxt, hcnt_inc;
  logic [COL_W-1:0] coltot_r, coltot_nxt;
  logic [ROW_W-1:0] rowtot_r, rowtot_nxt;
  logic [ROW_W-1:0] currow_r, currow_nxt;
  logic [RWL_W-1:0] wleft_r, wleft_nxt;
  logic [COL_W-1:0] curcol_r, curcol_nxt;

  logic             accept;
  logic [7:0]       run;
  logic [SUM_W-1:0] end_sum;
  logic [COL_W-1:0] end_col;
  logic [ROW_W-1:0] span_row;
  logic [COL_W-1:0] span_col;
  logic [7:0]       span_len;
  logic             span_clip;
  logic             span_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign run      = in_word[15:8];

  // Parse step for one accepted halfword
  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    coltot_nxt = coltot_r;
    rowtot_nxt = rowtot_r;
    currow_nxt = currow_r;
    wleft_nxt  = wleft_r;
    curcol_nxt = curcol_r;
    hcnt_inc   = '0;
    end_sum    = '0;
    end_col    = '0;
    span_row   = currow_r;
    span_col   = curcol_r;
    span_len   = '0;
    span_clip  = 1'b0;
    span_done  = 1'b0;
    push       = 1'b0;
    if (accept) begin
      if (in_packet_start) begin
        phase_nxt  = rcsd_pkg::PH_HEADER;
        hcnt_nxt   = '0;
        coltot_nxt = '0;
        rowtot_nxt = '0;
        currow_nxt = '0;
        wleft_nxt  = '0;
        curcol_nxt = '0;
      end
      span_row = currow_nxt;
      span_col = curcol_nxt;
      hcnt_inc = hcnt_nxt + HCW'(1);
      case (phase_nxt)
        rcsd_pkg::PH_HEADER: begin
          if (32'(hcnt_nxt) == COLS_FIELD_POS) begin
            coltot_nxt = (in_word > 16'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : COL_W'(in_word);
          end
          if (32'(hcnt_nxt) == ROWS_FIELD_POS) begin
            rowtot_nxt = (in_word > 16'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(in_word);
          end
          hcnt_nxt = hcnt_inc;
          if (32'(hcnt_inc) >= HEADER_WORDS) begin
            hcnt_nxt   = '0;
            currow_nxt = '0;
            phase_nxt  = (rowtot_nxt == '0) ? rcsd_pkg::PH_IDLE : rcsd_pkg::PH_ROWHDR;
          end
        end
        rcsd_pkg::PH_ROWHDR: begin
          if (hcnt_nxt == '0) begin
            wleft_nxt = in_word[15:1];
          end
          hcnt_nxt = hcnt_inc;
          if (32'(hcnt_inc) >= ROW_HEADER_WORDS) begin
            hcnt_nxt   = '0;
            curcol_nxt = '0;
            if (wleft_nxt == '0) begin
              // empty row: move on
              currow_nxt = currow_nxt + ROW_W'(1);
              wleft_nxt  = '0;
              phase_nxt  = (currow_nxt >= rowtot_nxt) ? rcsd_pkg::PH_IDLE
                                                       : rcsd_pkg::PH_ROWHDR;
            end else begin
              phase_nxt = rcsd_pkg::PH_DATA;
            end
          end
        end
        rcsd_pkg::PH_DATA: begin
          if (curcol_nxt < coltot_nxt) begin
            end_sum = SUM_W'(curcol_nxt) + SUM_W'(run);
            if (end_sum > SUM_W'(coltot_nxt)) begin
              end_col   = coltot_nxt;
              span_clip = 1'b1;
            end else begin
              end_col = end_sum[COL_W-1:0];
            end
            span_len = 8'(end_col - curcol_nxt);
          end else begin
            end_col   = coltot_nxt;
            span_clip = (run != 8'd0);
          end
          curcol_nxt = end_col;
          wleft_nxt  = wleft_nxt - RWL_W'(1);
          if (wleft_nxt == '0) begin
            // last halfword of the row
            currow_nxt = currow_nxt + ROW_W'(1);
            hcnt_nxt   = '0;
            curcol_nxt = '0;
            if (currow_nxt >= rowtot_nxt) begin
              phase_nxt = rcsd_pkg::PH_IDLE;
              span_done = 1'b1;
            end else begin
              phase_nxt = rcsd_pkg::PH_ROWHDR;
            end
          end
          push = (span_len != 8'd0) || span_done;
        end
        default: begin
          phase_nxt = rcsd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  assign push_cmd.row   = rcsd_pkg::ROW_NUM_W'(span_row);
  assign push_cmd.col   = rcsd_pkg::COL_NUM_W'(span_col);
  assign push_cmd.len   = span_len;
  assign push_cmd.level = in_word[7:0];
  assign push_cmd.clip  = span_clip;
  assign push_cmd.done  = span_done;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rcsd_pkg::PH_IDLE;
      hcnt_r   <= '0;
      coltot_r <= '0;
      rowtot_r <= '0;
      currow_r <= '0;
      wleft_r  <= '0;
      curcol_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      coltot_r <= coltot_nxt;
      rowtot_r <= rowtot_nxt;
      currow_r <= currow_nxt;
      wleft_r  <= wleft_nxt;
      curcol_r <= curcol_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rcsd_queue.sv -----
// Short span command queue between parser and colour stage.
`default_nettype none

module rcsd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rcsd_pkg::span_cmd_t push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output rcsd_pkg::span_cmd_t      head,
  output logic                     empty
);

  localparam int DEPTH = rcsd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rcsd_pkg::span_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("span queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("span queue read while empty");

endmodule

`default_nettype wire

// ----- sv/rcsd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rcsd_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rcsd_pkg::DIV_W-1:0] dividend,
  input  wire logic [rcsd_pkg::DIV_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [rcsd_pkg::DIV_W-1:0]      quotient
);

  localparam int W     = rcsd_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       trial;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = W'(trial - {1'b0, dsr_r});
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- sv/rcsd_back.sv -----
// Colour stage: level to palette index mapping, config registers and result register.
`default_nettype none

module rcsd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rcsd_pkg::cfg_wr_t   cfg_wr,
  input  wire rcsd_pkg::span_cmd_t head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rcsd_pkg::result_t        out_data
);

  localparam int W  = rcsd_pkg::DIV_W;
  localparam int SW = 12;

  // Clamp a signed value into the palette index range
  function automatic logic [7:0] sat8(input logic signed [SW-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  rcsd_pkg::back_state_t state_r, state_nxt;
  logic [7:0]          lead_r, trail_r;
  logic [8:0]          total_r, pal_r;
  logic                scale_dirty_r, scale_dirty_nxt;
  logic [W-1:0]        scale_r, scale_nxt;
  rcsd_pkg::span_cmd_t cmd_r, cmd_nxt;
  logic [7:0]          color_r, color_nxt;
  logic                out_valid_r;
  rcsd_pkg::result_t   out_data_r;
  logic                out_load;

  logic [8:0]           tot_eff, pal_eff;
  logic signed [SW-1:0] s_tot, s_pal, s_lead, s_trail, s_nflags, s_lv;
  logic signed [SW-1:0] s_a, s_b, last_data_lvl, last_num, c_hi, c_mid;
  logic                 pal_le_flags;

  logic         div_start, div_busy, div_done;
  logic [W-1:0] div_dividend, div_divisor, div_q;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 8'd0;
      trail_r <= 8'd0;
      total_r <= 9'd256;
      pal_r   <= 9'd256;
    end else if (cfg_wr.valid) begin
      case (rcsd_pkg::cfg_reg_t'(cfg_wr.index))
        rcsd_pkg::CFG_LEAD_FLAGS:     lead_r  <= cfg_wr.data[7:0];
        rcsd_pkg::CFG_TRAIL_FLAGS:    trail_r <= cfg_wr.data[7:0];
        rcsd_pkg::CFG_TOTAL_LEVELS:   total_r <= cfg_wr.data;
        rcsd_pkg::CFG_PALETTE_COLORS: pal_r   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Config-derived terms
  always_comb begin
    tot_eff       = (total_r == 9'd0) ? 9'd1 : ((total_r > 9'd256) ? 9'd256 : total_r);
    pal_eff       = (pal_r == 9'd0) ? 9'd1 : ((pal_r > 9'd256) ? 9'd256 : pal_r);
    s_tot         = $signed(SW'(tot_eff));
    s_pal         = $signed(SW'(pal_eff));
    s_lead        = $signed(SW'(lead_r));
    s_trail       = $signed(SW'(trail_r));
    s_nflags      = s_lead + s_trail;
    s_lv          = $signed(SW'(cmd_r.level));
    s_a           = s_tot - s_nflags;
    s_b           = s_pal - s_nflags;
    pal_le_flags  = (s_pal <= s_nflags);
    last_data_lvl = s_tot - s_trail - SW'(1);
    last_num      = s_pal - s_nflags;
    c_hi          = last_num + (s_lv - last_data_lvl);
    c_mid         = $signed(SW'(div_q)) + s_lead;
    if (c_mid > last_num) begin
      c_mid = last_num;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    scale_dirty_nxt = scale_dirty_r;
    scale_nxt       = scale_r;
    cmd_nxt         = cmd_r;
    color_nxt       = color_r;
    pop             = 1'b0;
    div_start       = 1'b0;
    div_dividend    = W'(s_a + s_b - SW'(1));
    div_divisor     = W'(s_b);
    out_load        = 1'b0;
    case (state_r)
      rcsd_pkg::BK_IDLE: begin
        if (scale_dirty_r) begin
          if (pal_le_flags) begin
            scale_nxt       = tot_eff;
            scale_dirty_nxt = 1'b0;
          end else if (s_a <= 0) begin
            scale_nxt       = W'(1);
            scale_dirty_nxt = 1'b0;
          end else begin
            // ceiling of data levels over data colours; a later write marks it stale again
            div_start       = 1'b1;
            scale_dirty_nxt = 1'b0;
            state_nxt       = rcsd_pkg::BK_SCALE;
          end
        end else if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = head;
          state_nxt = rcsd_pkg::BK_CLASS;
        end
      end
      rcsd_pkg::BK_SCALE: begin
        if (div_done) begin
          scale_nxt = (div_q == '0) ? W'(1) : div_q;
          state_nxt = rcsd_pkg::BK_IDLE;
        end
      end
      rcsd_pkg::BK_CLASS: begin
        if (s_lv < s_lead) begin
          // leading flag maps to itself
          color_nxt = cmd_r.level;
          state_nxt = rcsd_pkg::BK_DONE;
        end else if (s_lv > last_data_lvl) begin
          // trailing flag after the data colours
          color_nxt = sat8(c_hi);
          state_nxt = rcsd_pkg::BK_DONE;
        end else begin
          div_dividend = W'(s_lv - s_lead);
          div_divisor  = scale_r;
          div_start    = 1'b1;
          state_nxt    = rcsd_pkg::BK_COLOR;
        end
      end
      rcsd_pkg::BK_COLOR: begin
        if (div_done) begin
          color_nxt = sat8(c_mid);
          state_nxt = rcsd_pkg::BK_DONE;
        end
      end
      rcsd_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = rcsd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rcsd_pkg::BK_IDLE;
      end
    endcase
  end

  rcsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rcsd_pkg::BK_IDLE;
      scale_dirty_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scale_dirty_r <= scale_dirty_nxt;
      if (cfg_wr.valid) begin
        scale_dirty_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scale_r <= scale_nxt;
    cmd_r   <= cmd_nxt;
    color_r <= color_nxt;
    if (out_load) begin
      out_data_r.row_number   <= cmd_r.row;
      out_data_r.start_column <= cmd_r.col;
      out_data_r.span_length  <= cmd_r.len;
      out_data_r.level_byte   <= cmd_r.level;
      out_data_r.color_index  <= color_r;
      out_data_r.clipped      <= cmd_r.clip;
      out_data_r.packet_done  <= cmd_r.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_scale_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rcsd_pkg::BK_CLASS) |-> !scale_dirty_r)
    else $error("span classified with a stale scale");

  a_empty_span_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.span_length == '0) |-> out_data_r.packet_done)
    else $error("empty span without end of packet");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// ----- sv/rle_raster_color_span_decoder_unit.sv -----
// Flow: a span passes the span queue, the command register and the classify state, then for a
// data level the nine-step divider, before the result register; after reset or a register write
// the palette scale is recomputed first, and again if a write lands mid-recompute.
// Throughput: one halfword per cycle while the two-entry span queue has room; the colour
// stage takes no new span until the last one is loaded into the result register.
// Reset: synchronous active-low; parser idle, queue empty, registers to reset values.
`default_nettype none

module rle_raster_color_span_decoder_unit #(
  parameter int MAX_ROWS         = rcsd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS      = rcsd_pkg::MAX_COLUMNS_DEF,
  parameter int HEADER_WORDS     = rcsd_pkg::HEADER_WORDS_DEF,
  parameter int ROW_HEADER_WORDS = rcsd_pkg::ROW_HEADER_WORDS_DEF,
  parameter int COLS_FIELD_POS   = rcsd_pkg::COLS_FIELD_POS_DEF,
  parameter int ROWS_FIELD_POS   = rcsd_pkg::ROWS_FIELD_POS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rcsd_in_if.sink    in_ch,
  rcsd_out_if.source out_ch,
  rcsd_cfg_if.sink   cfg_ch
);

  logic                push, q_full, q_empty, pop;
  rcsd_pkg::span_cmd_t push_cmd, head;
  rcsd_pkg::cfg_wr_t   cfg_wr;
  rcsd_pkg::result_t   out_data;
  logic                out_valid;

  // Register writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.valid = cfg_ch.valid;
  assign cfg_wr.index = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  rcsd_front #(
    .MAX_ROWS         (MAX_ROWS),
    .MAX_COLUMNS      (MAX_COLUMNS),
    .HEADER_WORDS     (HEADER_WORDS),
    .ROW_HEADER_WORDS (ROW_HEADER_WORDS),
    .COLS_FIELD_POS   (COLS_FIELD_POS),
    .ROWS_FIELD_POS   (ROWS_FIELD_POS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_word         (in_ch.word),
    .in_packet_start (in_ch.packet_start),
    .push            (push),
    .push_cmd        (push_cmd),
    .q_full          (q_full)
  );

  rcsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  rcsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.row_number   = out_data.row_number;
  assign out_ch.start_column = out_data.start_column;
  assign out_ch.span_length  = out_data.span_length;
  assign out_ch.level_byte   = out_data.level_byte;
  assign out_ch.color_index  = out_data.color_index;
  assign out_ch.clipped      = out_data.clipped;
  assign out_ch.packet_done  = out_data.packet_done;

endmodule

`default_nettype wire
